// File: hdl/nlr_pkg.sv
package nlr_pkg;

   localparam int MAX_LEN = 255;
   localparam int LEN_CAP_INT = (MAX_LEN < 255) ? MAX_LEN : 255;
   localparam logic [7:0] LEN_CAP = 8'(LEN_CAP_INT);

   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] CSR_FEATURE_FLAGS = 2'd0;
   localparam logic [1:0] CSR_SEPARATOR_CHAR = 2'd1;
   localparam logic [1:0] CSR_SEPARATOR_ENABLE = 2'd2;

   localparam logic [10:0] FLAGS_RESET = 11'd0;
   localparam logic [7:0] SEPARATOR_RESET = 8'h5F;

   localparam int FLAG_HEX = 0;
   localparam int FLAG_OCT = 1;
   localparam int FLAG_BIN = 2;
   localparam int FLAG_STOP = 3;
   localparam int FLAG_EXP = 4;
   localparam int FLAG_ULL = 5;
   localparam int FLAG_D = 6;
   localparam int FLAG_F = 7;
   localparam int FLAG_J = 8;
   localparam int FLAG_L = 9;
   localparam int FLAG_I = 10;

   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_ONE = 8'h31;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_LA = 8'h61;
   localparam logic [7:0] CH_LF = 8'h66;
   localparam logic [7:0] CH_UA = 8'h41;
   localparam logic [7:0] CH_UF = 8'h46;
   localparam logic [7:0] CH_LX = 8'h78;
   localparam logic [7:0] CH_UX = 8'h58;
   localparam logic [7:0] CH_LO = 8'h6F;
   localparam logic [7:0] CH_UO = 8'h4F;
   localparam logic [7:0] CH_LB = 8'h62;
   localparam logic [7:0] CH_UB = 8'h42;
   localparam logic [7:0] CH_LE = 8'h65;
   localparam logic [7:0] CH_UE = 8'h45;
   localparam logic [7:0] CH_LU = 8'h75;
   localparam logic [7:0] CH_UU = 8'h55;
   localparam logic [7:0] CH_LL = 8'h6C;
   localparam logic [7:0] CH_UL = 8'h4C;
   localparam logic [7:0] CH_LD = 8'h64;
   localparam logic [7:0] CH_UD = 8'h44;
   localparam logic [7:0] CH_UFF = 8'h46;
   localparam logic [7:0] CH_LJ = 8'h6A;
   localparam logic [7:0] CH_UJ = 8'h4A;
   localparam logic [7:0] CH_LI = 8'h69;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
      logic       dig;
      logic       zero;
      logic       dot;
      logic       sep;
      logic       hexd;
      logic       octd;
      logic       bdig;
      logic       pfx_ok;
      logic       exp_ok;
      logic       minus;
      logic       ul_ok;
      logic       single_ok;
      logic       stop;
   } nlr_item_type;

endpackage

// File: hdl/nlr_front.sv
module nlr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [10:0]          csr_wdata,
   input  logic [7:0]           req_char_in,
   input  logic                 req_last_char,
   output nlr_pkg::nlr_item_type item
);
   import nlr_pkg::*;

   logic [10:0] flags_ff;
   logic [7:0]  sep_char_ff;
   logic        sep_en_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= FLAGS_RESET;
         sep_char_ff <= SEPARATOR_RESET;
         sep_en_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FEATURE_FLAGS: flags_ff <= csr_wdata;
            CSR_SEPARATOR_CHAR: sep_char_ff <= csr_wdata[7:0];
            CSR_SEPARATOR_ENABLE: sep_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [7:0] c;
   assign c = req_char_in;

   always_comb begin
      item = '0;
      item.char_code = c;
      item.last = req_last_char;
      item.dig = (c >= CH_ZERO) && (c <= CH_NINE);
      item.zero = (c == CH_ZERO);
      item.dot = (c == CH_DOT);
      item.sep = sep_en_ff && (c == sep_char_ff);
      item.hexd = item.dig || ((c >= CH_LA) && (c <= CH_LF))
                  || ((c >= CH_UA) && (c <= CH_UF));
      item.octd = (c >= CH_ZERO) && (c <= CH_SEVEN);
      item.bdig = (c == CH_ZERO) || (c == CH_ONE);
      item.pfx_ok = (flags_ff[FLAG_HEX] && ((c == CH_LX) || (c == CH_UX)))
                    || (flags_ff[FLAG_OCT] && ((c == CH_LO) || (c == CH_UO)))
                    || (flags_ff[FLAG_BIN] && ((c == CH_LB) || (c == CH_UB)));
      item.exp_ok = flags_ff[FLAG_EXP] && ((c == CH_LE) || (c == CH_UE));
      item.minus = (c == CH_MINUS);
      item.ul_ok = flags_ff[FLAG_ULL] && ((c == CH_LU) || (c == CH_UU)
                   || (c == CH_LL) || (c == CH_UL));
      item.single_ok = (flags_ff[FLAG_D] && ((c == CH_LD) || (c == CH_UD)))
                       || (flags_ff[FLAG_F] && ((c == CH_LF) || (c == CH_UFF)))
                       || (flags_ff[FLAG_J] && ((c == CH_LJ) || (c == CH_UJ)))
                       || (flags_ff[FLAG_L] && ((c == CH_LL) || (c == CH_UL)))
                       || (flags_ff[FLAG_I] && (c == CH_LI));
      item.stop = flags_ff[FLAG_STOP];
   end

endmodule

// File: hdl/nlr_queue.sv
module nlr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  nlr_pkg::nlr_item_type push_item,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output nlr_pkg::nlr_item_type pop_item
);
   import nlr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   nlr_item_type entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid = (count_ff != '0);
   assign pop_item = entry_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (pop) rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_item;
   end

endmodule

// File: hdl/nlr_back.sv
module nlr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   output logic                 item_ready,
   input  nlr_pkg::nlr_item_type item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_match_length,
   output logic                 rsp_length_saturated
);
   import nlr_pkg::*;

   typedef enum logic [12:0] {
      PH_START = 13'b0000000000001,
      PH_DOT   = 13'b0000000000010,
      PH_ZERO  = 13'b0000000000100,
      PH_PFX   = 13'b0000000001000,
      PH_HEX   = 13'b0000000010000,
      PH_OCT   = 13'b0000000100000,
      PH_BIN   = 13'b0000001000000,
      PH_DEC   = 13'b0000010000000,
      PH_ESIGN = 13'b0000100000000,
      PH_EXP   = 13'b0001000000000,
      PH_SUF0  = 13'b0010000000000,
      PH_SUF   = 13'b0100000000000,
      PH_DONE  = 13'b1000000000000
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [1:0] bumps;
      logic       la_set;
      logic       done;
   } step_type;

   function automatic step_type f_suf0(nlr_item_type it, phase_type cur);
      step_type s;
      s = '{phase: cur, bumps: 2'd0, la_set: 1'b0, done: 1'b0};
      if (it.ul_ok) begin
         s.phase = PH_SUF;
         s.bumps = 2'd1;
         s.la_set = 1'b1;
      end else begin
         s.phase = PH_SUF0;
         s.bumps = {1'b0, it.single_ok};
         s.done = 1'b1;
      end
      return s;
   endfunction

   function automatic step_type f_dec(nlr_item_type it, phase_type cur);
      step_type s;
      s = '{phase: PH_DEC, bumps: 2'd1, la_set: 1'b0, done: 1'b0};
      if (!(it.dig || it.sep || it.dot)) begin
         if (it.exp_ok) s.phase = PH_ESIGN;
         else s = f_suf0(it, cur);
      end
      return s;
   endfunction

   function automatic step_type f_exp(nlr_item_type it, phase_type cur);
      step_type s;
      s = '{phase: PH_EXP, bumps: 2'd1, la_set: 1'b0, done: 1'b0};
      if (!(it.dig || it.sep || it.dot)) s = f_suf0(it, cur);
      return s;
   endfunction

   function automatic step_type f_radix(nlr_item_type it, phase_type ph, phase_type cur);
      step_type s;
      logic ok;
      s = '{phase: ph, bumps: 2'd1, la_set: 1'b0, done: 1'b0};
      ok = (ph == PH_HEX) ? it.hexd : ((ph == PH_OCT) ? it.octd : it.bdig);
      if (!(ok || it.sep)) begin
         if (it.stop) begin
            s.bumps = 2'd0;
            s.done = 1'b1;
         end else begin
            s = f_dec(it, cur);
         end
      end
      return s;
   endfunction

   phase_type  phase_ff, phase_in;
   logic [7:0] count_ff, count_in;
   logic       ovf_ff, ovf_in;
   logic [7:0] la_ff, la_in;
   logic [1:0] sp_ff, sp_in;
   logic       given_ff, given_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_len_ff;
   logic       rsp_sat_ff;

   step_type   s;
   phase_type  pfx_kind;
   logic       want_l;
   logic       pop, emit;
   logic [7:0] c;

   assign c = item.char_code;
   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign pop = item_valid && item_ready;

   always_comb begin
      if ((la_ff == CH_LX) || (la_ff == CH_UX)) pfx_kind = PH_HEX;
      else if ((la_ff == CH_LO) || (la_ff == CH_UO)) pfx_kind = PH_OCT;
      else pfx_kind = PH_BIN;
      want_l = ((la_ff == CH_LU) && (c == CH_LL)) || ((la_ff == CH_UU) && (c == CH_UL));
   end

   always_comb begin
      s = '{phase: phase_ff, bumps: 2'd0, la_set: 1'b0, done: 1'b0};
      unique case (phase_ff) inside
         PH_START: begin
            if (item.dig) begin
               s.bumps = 2'd1;
               s.phase = item.zero ? PH_ZERO : PH_DEC;
            end else if (item.dot) begin
               s.phase = PH_DOT;
            end else begin
               s.done = 1'b1;
            end
         end
         PH_DOT: begin
            if (item.dig) begin
               s.bumps = 2'd2;
               s.phase = PH_DEC;
            end else begin
               s.done = 1'b1;
            end
         end
         PH_ZERO: begin
            if (item.pfx_ok) begin
               s.la_set = 1'b1;
               s.phase = PH_PFX;
            end else begin
               s = f_dec(item, phase_ff);
            end
         end
         PH_PFX: begin
            s = f_radix(item, pfx_kind, phase_ff);
            s.bumps = s.bumps + 2'd1;
         end
         PH_HEX, PH_OCT, PH_BIN: s = f_radix(item, phase_ff, phase_ff);
         PH_DEC: s = f_dec(item, phase_ff);
         PH_ESIGN: begin
            if (item.minus) begin
               s.bumps = 2'd1;
               s.phase = PH_EXP;
            end else begin
               s = f_exp(item, phase_ff);
            end
         end
         PH_EXP: s = f_exp(item, phase_ff);
         PH_SUF0: s = f_suf0(item, phase_ff);
         PH_SUF: begin
            s.done = 1'b1;
            if (sp_ff == 2'd1) begin
               if (want_l) begin
                  s.bumps = 2'd1;
                  s.done = 1'b0;
               end else if (((la_ff == CH_LL) && (c == CH_LL))
                            || ((la_ff == CH_UL) && (c == CH_UL))) begin
                  s.bumps = 2'd1;
               end
            end else begin
               s.bumps = {1'b0, want_l};
            end
         end
         default: s.done = 1'b1;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      la_in = la_ff;
      sp_in = sp_ff;
      given_in = given_ff;
      emit = 1'b0;
      if (pop) begin
         if (!given_ff) begin
            for (int i = 0; i < 2; i++) begin
               if (2'(i) < s.bumps) begin
                  if (count_in < LEN_CAP) count_in = count_in + 8'd1;
                  else ovf_in = 1'b1;
               end
            end
            phase_in = s.phase;
            if (s.la_set) la_in = c;
            else if (phase_ff == PH_PFX) la_in = '0;
            if (s.phase == PH_SUF && phase_ff != PH_SUF) sp_in = 2'd1;
            else if (phase_ff == PH_SUF && sp_ff == 2'd1 && want_l) sp_in = 2'd2;
            if (s.done || item.last) begin
               emit = 1'b1;
               given_in = 1'b1;
               phase_in = PH_DONE;
            end
         end
         if (item.last) begin
            phase_in = PH_START;
            la_in = '0;
            sp_in = '0;
            given_in = 1'b0;
         end
      end
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         la_ff <= '0;
         sp_ff <= '0;
         given_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= (pop && item.last) ? '0 : count_in;
         ovf_ff <= (pop && item.last) ? 1'b0 : ovf_in;
         la_ff <= la_in;
         sp_ff <= sp_in;
         given_ff <= given_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_len_ff <= count_in;
         rsp_sat_ff <= ovf_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_match_length = rsp_len_ff;
   assign rsp_length_saturated = rsp_sat_ff;

   a_given_done: assert property (@(posedge clock) disable iff (reset)
      given_ff == (phase_ff == PH_DONE))
      else $error("result flag and done phase disagree");

   a_sat_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_sat_ff |-> rsp_len_ff == LEN_CAP)
      else $error("saturated length below cap");

   a_suf_prog: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SUF) |-> (sp_ff != 2'd0))
      else $error("suffix phase without progress");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      pop && item.last |=> phase_ff == PH_START && count_ff == 8'd0 && !ovf_ff)
      else $error("end mark did not clear state");

endmodule

// File: hdl/numeric_literal_recognizer.sv
// The request that ends a literal is queued, then the back end registers rsp_valid.
// One request per cycle, set by the back-end recognizer step, while the queue has room.
// A two-entry queue decouples request acceptance from response stalls.
// Reset: synchronous, active high; clears recognizer state, queue and response register,
// and returns configuration to its defaults. No clearing pass is needed.
module numeric_literal_recognizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_match_length,
   output logic        rsp_length_saturated,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);
   import nlr_pkg::*;

   nlr_item_type front_item;
   nlr_item_type q_item;
   logic         q_valid;
   logic         q_ready;

   nlr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_char_in   (req_char_in),
      .req_last_char (req_last_char),
      .item          (front_item)
   );

   nlr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_item  (front_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   nlr_back u_back (
      .clock                (clock),
      .reset                (reset),
      .item_valid           (q_valid),
      .item_ready           (q_ready),
      .item                 (q_item),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_match_length     (rsp_match_length),
      .rsp_length_saturated (rsp_length_saturated)
   );

endmodule
